>>> rtl/core/sscs_pkg.sv
// Shared types, constants and helpers for the substring and character-set search block.
// Used by sscs_match, sscs_outbuf and substring_and_charset_search.
`timescale 1ns / 1ps

package sscs_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int INDEX_BITS        = 16;
  localparam int POS_BITS          = INDEX_BITS + 1;
  localparam int WIN_BITS          = 8 * (MAX_PATTERN_BYTES - 1);
  localparam int PAT_BITS          = 8 * MAX_PATTERN_BYTES;
  localparam int LEN_BITS          = 4;
  localparam int PAT_IDX_BITS      = 3;
  localparam int CFG_IDX_BITS      = 2;
  localparam int RESULT_BITS       = 2 * INDEX_BITS + 2;
  localparam int OUT_TDATA_BITS    = ((RESULT_BITS + 7) / 8) * 8;

  localparam logic [INDEX_BITS-1:0] IDX_MAX   = '1;
  localparam logic [POS_BITS-1:0]   POS_LIMIT = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SEARCH_MODE    = 2'd0,
    CFG_PATTERN_BYTES  = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_SUBSTRING = 1'b0,
    MODE_CHARSET   = 1'b1
  } search_mode_t;

  typedef struct packed {
    search_mode_t          mode;
    logic [PAT_BITS-1:0]   pattern;
    logic [LEN_BITS-1:0]   length;
  } cfg_t;

  typedef struct packed {
    logic                  hit;
    logic [INDEX_BITS-1:0] start;
  } hit_t;

  // packed from the top bit down, so found lands in bit 0
  typedef struct packed {
    logic                  overflow;
    logic [INDEX_BITS-1:0] last_index;
    logic [INDEX_BITS-1:0] first_index;
    logic                  found;
  } result_t;

  // clamp the programmed length into 1..MAX_PATTERN_BYTES
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] n);
    logic [LEN_BITS-1:0] r;
    r = n;
    if (n == '0) begin
      r = LEN_BITS'(1);
    end else if (n > LEN_BITS'(MAX_PATTERN_BYTES)) begin
      r = LEN_BITS'(MAX_PATTERN_BYTES);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/sscs_match.sv
// Byte compare for one incoming word: pattern window check or character-set check.
// Combinational; depends on sscs_pkg.
`timescale 1ns / 1ps

module sscs_match
  import sscs_pkg::*;
(
  input  cfg_t                cfg,
  input  logic [WIN_BITS-1:0] window,
  input  logic [7:0]          text_byte,
  input  logic [POS_BITS-1:0] pos,
  output hit_t                result
);

  logic [LEN_BITS-1:0]     len;
  logic [PAT_IDX_BITS-1:0] len_m1;
  logic [PAT_BITS-1:0]     hist;
  logic [MAX_PATTERN_BYTES-1:0] sub_eq;
  logic [MAX_PATTERN_BYTES-1:0] set_eq;
  logic [POS_BITS-1:0]     start_raw;

  assign len    = eff_len(cfg.length);
  assign len_m1 = PAT_IDX_BITS'(len - LEN_BITS'(1));
  assign hist   = {window, text_byte};

  always_comb begin
    logic [PAT_IDX_BITS-1:0] idx;
    logic [7:0]              pat;
    logic                    active;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      pat       = cfg.pattern[8*j +: 8];
      active    = LEN_BITS'(j) < len;
      idx       = len_m1 - PAT_IDX_BITS'(j);
      sub_eq[j] = !active || (pat == hist[8*idx +: 8]);
      set_eq[j] = active && (pat == text_byte);
    end
  end

  always_comb begin
    result.hit = 1'b0;
    start_raw  = pos;
    unique case (cfg.mode)
      MODE_CHARSET: begin
        result.hit = |set_eq;
        start_raw  = pos;
      end
      MODE_SUBSTRING: begin
        result.hit = (&sub_eq) && (pos >= POS_BITS'(len_m1));
        start_raw  = pos - POS_BITS'(len_m1);
      end
      default: begin
        result.hit = 1'b0;
      end
    endcase
    result.start = start_raw[POS_BITS-1] ? IDX_MAX : start_raw[INDEX_BITS-1:0];
  end

endmodule

>>> rtl/core/sscs_outbuf.sv
// Result register with one skid entry between the search core and the output channel.
// Depends on sscs_pkg.
`timescale 1ns / 1ps

module sscs_outbuf
  import sscs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  assign pop        = out_v_r && out_ready;
  assign can_accept = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        out_v_nxt  = push;
        out_d_nxt  = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("result pushed with skid entry occupied");

endmodule

>>> rtl/core/substring_and_charset_search.sv
// Top level of the streaming substring / character-set search block.
// Instantiates sscs_match and sscs_outbuf; depends on sscs_pkg.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one text byte per word in in_tdata, in_tlast marks the final byte of a string.
//   out_* : one word per string, sent after its final byte; tdata from bit 0 up:
//           found, first_index[15:0], last_index[15:0], overflow, zero padding.
//   cfg_* : write port; index 0 search mode, 1 pattern bytes, 2 pattern length.
//           Write only while no string is in progress and no result is pending.
// Throughput: one byte per cycle while in_tready is high; the byte compare and state
//   update finish in the cycle the word is accepted.
// Output: the result word is registered when the final byte is accepted.
// Stall: a result register plus one skid entry hold results; in_tready is registered
//   and drops only when both are full, so bytes of a string keep flowing while the
//   previous result waits.
// Reset: rst_n (synchronous) clears the string state, empties the output side and
//   loads mode 0, pattern 0, length 1. No match can be pending after reset.
module substring_and_charset_search
  import sscs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,  // text_byte
  input  logic                      in_tlast,  // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata, // found, first_index, last_index, overflow
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [PAT_BITS-1:0]       cfg_data
);

  cfg_t                  cfg_r, cfg_nxt;
  logic [WIN_BITS-1:0]   window_r, window_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [INDEX_BITS-1:0] first_r, first_nxt;
  logic [INDEX_BITS-1:0] last_r, last_nxt;
  logic                  any_r, any_nxt;
  logic                  ovf_r, ovf_nxt;

  hit_t                  hit;
  result_t               res;
  result_t               out_res;
  logic                  fire;
  logic                  push;
  logic                  at_limit;
  logic [INDEX_BITS-1:0] str_len;
  logic                  any_upd;
  logic                  ovf_upd;
  logic [INDEX_BITS-1:0] first_upd;
  logic [INDEX_BITS-1:0] last_upd;

  assign fire = in_tvalid && in_tready;
  assign push = fire && in_tlast;

  sscs_match u_match (
    .cfg       (cfg_r),
    .window    (window_r),
    .text_byte (in_tdata),
    .pos       (pos_r),
    .result    (hit)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEARCH_MODE:    cfg_nxt.mode    = search_mode_t'(cfg_data[0]);
        CFG_PATTERN_BYTES:  cfg_nxt.pattern = cfg_data;
        CFG_PATTERN_LENGTH: cfg_nxt.length  = cfg_data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign at_limit  = pos_r >= POS_BITS'(IDX_MAX);
  assign str_len   = at_limit ? IDX_MAX : pos_r[INDEX_BITS-1:0] + INDEX_BITS'(1);
  assign any_upd   = any_r || hit.hit;
  assign ovf_upd   = ovf_r || at_limit;
  assign first_upd = (hit.hit && !any_r) ? hit.start : first_r;
  assign last_upd  = hit.hit ? hit.start : last_r;

  always_comb begin
    res.found       = any_upd;
    res.first_index = any_upd ? first_upd : str_len;
    res.last_index  = any_upd ? last_upd : str_len;
    res.overflow    = ovf_upd;
  end

  always_comb begin
    window_nxt = window_r;
    pos_nxt    = pos_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    any_nxt    = any_r;
    ovf_nxt    = ovf_r;
    if (fire) begin
      if (in_tlast) begin
        window_nxt = '0;
        pos_nxt    = '0;
        first_nxt  = '0;
        last_nxt   = '0;
        any_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
      end else begin
        window_nxt = {window_r[WIN_BITS-9:0], in_tdata};
        pos_nxt    = (pos_r == POS_LIMIT) ? pos_r : pos_r + POS_BITS'(1);
        first_nxt  = first_upd;
        last_nxt   = last_upd;
        any_nxt    = any_upd;
        ovf_nxt    = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_SUBSTRING;
      cfg_r.pattern <= '0;
      cfg_r.length  <= LEN_BITS'(1);
      window_r      <= '0;
      pos_r         <= '0;
      first_r       <= '0;
      last_r        <= '0;
      any_r         <= 1'b0;
      ovf_r         <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      window_r <= window_nxt;
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      any_r    <= any_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  sscs_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {(OUT_TDATA_BITS - RESULT_BITS)'(0), out_res.overflow,
                      out_res.last_index, out_res.first_index, out_res.found};

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (pos_r == '0) && !any_r && !ovf_r)
    else $error("string state not cleared after final byte");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_tlast && (pos_r != POS_LIMIT)) |=> pos_r == $past(pos_r) + POS_BITS'(1))
    else $error("byte position did not advance");

  a_first_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (any_r && !(fire && in_tlast)) |=> first_r == $past(first_r))
    else $error("first match position changed after a match was recorded");

endmodule

>>> tb/sv/substring_and_charset_search_tb.sv
// Self-checking bench for substring_and_charset_search: a directed table and random
// strings under four handshake mixes, checked against a local predictor.
// Depends on sscs_pkg and the substring_and_charset_search RTL.
`timescale 1ns / 1ps

module substring_and_charset_search_tb;
  import sscs_pkg::*;

  typedef enum {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    cfg_reg_t            idx;
    logic [PAT_BITS-1:0] value;
    logic [7:0]          text;
    logic                fin;
    bit                  typed;
    result_t             res;
  } dir_row_t;

  localparam int IDX_LIM = (1 << INDEX_BITS) - 1;
  localparam int POS_MAX = (1 << POS_BITS) - 1;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata   = '0;
  logic                      in_tlast   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
  logic [PAT_BITS-1:0]       cfg_data   = '0;

  // register copies
  search_mode_t        mode_r = MODE_SUBSTRING;
  logic [PAT_BITS-1:0] pat_r  = '0;
  logic [LEN_BITS-1:0] len_r  = LEN_BITS'(1);

  // per-string search state
  logic [WIN_BITS-1:0]   win       = '0;
  int                    pos       = 0;
  logic [INDEX_BITS-1:0] first_pos = '0;
  logic [INDEX_BITS-1:0] last_pos  = '0;
  bit                    any_hit   = 1'b0;
  bit                    ovf_seen  = 1'b0;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];
  int       sender_idle  = 0;
  int       recv_stall   = 0;
  int       mismatches   = 0;
  int       bytes_sent   = 0;
  int       strings_seen = 0;
  int       cfg_writes   = 0;

  substring_and_charset_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[substring_and_charset_search] ERROR");
    $finish;
  end

  function automatic int clamp_len(input logic [LEN_BITS-1:0] n);
    int r;
    r = n;
    if (r < 1) r = 1;
    if (r > MAX_PATTERN_BYTES) r = MAX_PATTERN_BYTES;
    return r;
  endfunction

  function automatic result_t mk_res(input bit f, input int first, input int last, input bit ovf);
    result_t r;
    r.found       = f;
    r.first_index = INDEX_BITS'(first);
    r.last_index  = INDEX_BITS'(last);
    r.overflow    = ovf;
    return r;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic fin,
                           output bit has_res, output result_t r);
    int n;
    int start;
    int slen;
    bit hit;
    logic [7:0] t;
    n = clamp_len(len_r);
    hit = 1'b0;
    start = pos;
    has_res = 1'b0;
    r = '0;
    if (mode_r == MODE_CHARSET) begin
      for (int j = 0; j < n; j++) begin
        if (pat_r[8*j +: 8] == b) hit = 1'b1;
      end
    end else if (pos >= n - 1) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (j == n - 1) begin
          t = b;
        end else begin
          t = win[8*(n-2-j) +: 8];
        end
        if (t != pat_r[8*j +: 8]) hit = 1'b0;
      end
      start = pos - (n - 1);
    end
    if (hit) begin
      if (start > IDX_LIM) start = IDX_LIM;
      if (!any_hit) first_pos = INDEX_BITS'(start);
      last_pos = INDEX_BITS'(start);
      any_hit = 1'b1;
    end
    if (pos >= IDX_LIM) ovf_seen = 1'b1;
    slen = pos + 1;
    if (slen > IDX_LIM) slen = IDX_LIM;
    win = {win[WIN_BITS-9:0], b};
    if (pos < POS_MAX) pos++;
    if (fin) begin
      has_res = 1'b1;
      r = any_hit ? mk_res(1'b1, first_pos, last_pos, ovf_seen)
                  : mk_res(1'b0, slen, slen, ovf_seen);
      win = '0;
      pos = 0;
      first_pos = '0;
      last_pos = '0;
      any_hit = 1'b0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input bit typed, input result_t typed_res);
    bit has_res;
    result_t r;
    if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    scan_byte(b, fin, has_res, r);
    if (has_res) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [PAT_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SEARCH_MODE:    mode_r = search_mode_t'(v[0]);
      CFG_PATTERN_BYTES:  pat_r  = v;
      CFG_PATTERN_LENGTH: len_r  = v[LEN_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic put_cfg(input cfg_reg_t idx, input logic [PAT_BITS-1:0] v);
    dir_row_t row;
    row = '{ROW_CFG, idx, v, 8'h00, 1'b0, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic put_byte(input logic [7:0] b);
    dir_row_t row;
    row = '{ROW_BYTE, CFG_SEARCH_MODE, '0, b, 1'b0, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic put_last(input logic [7:0] b, input result_t r);
    dir_row_t row;
    row = '{ROW_BYTE, CFG_SEARCH_MODE, '0, b, 1'b1, 1'b1, r};
    dir_rows.push_back(row);
  endtask

  // new random register settings; small alphabets keep matches frequent
  task automatic pick_search_setup();
    int r;
    logic [PAT_BITS-1:0] p;
    logic [LEN_BITS-1:0] n;
    quiesce();
    if ($urandom_range(99) < 60) begin
      write_reg(CFG_SEARCH_MODE, PAT_BITS'($urandom_range(1)));
    end
    if ($urandom_range(99) < 70) begin
      r = $urandom_range(9);
      if (r == 0) begin
        p = '0;
      end else if (r == 1) begin
        p = '1;
      end else if (r < 4) begin
        p = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) p[8*j +: 8] = 8'(8'h61 + $urandom_range(2));
      end
      write_reg(CFG_PATTERN_BYTES, p);
    end
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = '0;
      end else if (r < 16) begin
        n = LEN_BITS'($urandom_range(15, MAX_PATTERN_BYTES + 1));
      end else if (r < 30) begin
        n = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
        n = LEN_BITS'($urandom_range(MAX_PATTERN_BYTES, 1));
      end
      write_reg(CFG_PATTERN_LENGTH, PAT_BITS'(n));
    end
  endtask

  always @(posedge clk) begin : rx
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[RESULT_BITS-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: found=%0d first=%0d last=%0d ovf=%0d", $time,
                 got.found, got.first_index, got.last_index, got.overflow);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        strings_seen++;
        if (got !== want) begin
          $display("%0t mismatch: expected found=%0d first=%0d last=%0d ovf=%0d", $time,
                   want.found, want.first_index, want.last_index, want.overflow);
          $display("%0t           actual   found=%0d first=%0d last=%0d ovf=%0d", $time,
                   got.found, got.first_index, got.last_index, got.overflow);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin : stim
    logic [7:0] text_q[$];
    int phase_idle[4];
    int phase_stall[4];
    int target;
    int slen;
    int n;
    int r;
    int j0;

    phase_idle  = '{0, 86, 0, 14};
    phase_stall = '{0, 0, 86, 14};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: mode substring, pattern zero, length one
    put_last(8'h00, mk_res(1'b1, 0, 0, 1'b0));
    put_last(8'hFF, mk_res(1'b0, 1, 1, 1'b0));
    put_cfg(CFG_SEARCH_MODE, PAT_BITS'(MODE_CHARSET));
    put_cfg(CFG_PATTERN_BYTES, '1);
    put_cfg(CFG_PATTERN_LENGTH, PAT_BITS'(8));
    put_byte(8'h00);
    put_last(8'hFF, mk_res(1'b1, 1, 1, 1'b0));
    put_cfg(CFG_SEARCH_MODE, PAT_BITS'(MODE_SUBSTRING));
    put_cfg(CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    put_cfg(CFG_PATTERN_LENGTH, PAT_BITS'(3));
    // string shorter than the pattern
    put_byte(8'h61);
    put_last(8'h62, mk_res(1'b0, 2, 2, 1'b0));
    put_byte(8'h61);
    put_byte(8'h62);
    put_byte(8'h63);
    put_byte(8'h61);
    put_byte(8'h62);
    put_last(8'h63, mk_res(1'b1, 0, 3, 1'b0));
    // overlapping matches
    put_cfg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_6161);
    put_cfg(CFG_PATTERN_LENGTH, PAT_BITS'(2));
    put_byte(8'h61);
    put_byte(8'h61);
    put_last(8'h61, mk_res(1'b1, 0, 1, 1'b0));
    // length zero acts as one
    put_cfg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_0061);
    put_cfg(CFG_PATTERN_LENGTH, PAT_BITS'(0));
    put_byte(8'h78);
    put_last(8'h61, mk_res(1'b1, 1, 1, 1'b0));
    // length fifteen acts as eight
    put_cfg(CFG_PATTERN_BYTES, 64'h4847_4645_4443_4241);
    put_cfg(CFG_PATTERN_LENGTH, PAT_BITS'(15));
    for (int i = 0; i < 7; i++) put_byte(8'(8'h41 + i));
    put_last(8'h48, mk_res(1'b1, 0, 0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].text, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      sender_idle = phase_idle[ph];
      recv_stall  = phase_stall[ph];
      target = bytes_sent + 362;
      while (bytes_sent < target) begin
        if ($urandom_range(99) < 30) pick_search_setup();
        slen = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13);
        n = clamp_len(len_r);
        text_q.delete();
        while (text_q.size() < slen) begin
          r = $urandom_range(99);
          if (r < 25) begin
            for (int j = 0; j < n; j++) text_q.push_back(pat_r[8*j +: 8]);
          end else if (r < 70) begin
            j0 = $urandom_range(n - 1);
            text_q.push_back(pat_r[8*j0 +: 8]);
          end else begin
            text_q.push_back(8'($urandom));
          end
        end
        for (int i = 0; i < slen; i++) send_byte(text_q[i], i == slen - 1, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    recv_stall = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d strings, %0d text bytes, %0d register writes;",
             strings_seen, bytes_sent, cfg_writes);
    $display("both modes, clamped lengths, short and overlapping cases, four handshake mixes.");
    if (mismatches == 0) begin
      $display("[substring_and_charset_search] OK");
    end else begin
      $display("[substring_and_charset_search] ERROR");
    end
    $finish;
  end

endmodule
